### design/note_to_cv_voice_mapper_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the note to CV voice mapper
// Implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NOTE_TO_CV_VOICE_MAPPER_TOP_ASSERT_SVH
`define NOTE_TO_CV_VOICE_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define NCVM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define NCVM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ncvm_pkg.sv
// ----------------------------------------------------------------------------
// ncvm_pkg
// Types, codes and constants shared by the note to CV voice mapper.
// ----------------------------------------------------------------------------
package ncvm_pkg;

    localparam int MAX_VOICES  = 4;
    localparam int TABLE_DEPTH = 128;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);

    localparam logic [12:0] OCTAVE_STEP = 13'd6553;
    localparam logic [17:0] GATE_ON     = 18'd4095;
    localparam logic [17:0] TRIG_LEVEL  = 18'd65535;
    localparam logic [15:0] VEL_RAMP    = 16'd3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PITCH_ENABLE = 3'd0,
        REG_VOICE_COUNT  = 3'd1,
        REG_TRANSPOSE    = 3'd2,
        REG_NOTES_OCT    = 3'd3,
        REG_GLIDE_TIME   = 3'd4
    } ncvm_reg_t;

    // Item kinds
    typedef enum logic {
        FUNC_TABLE_WRITE = 1'b0,
        FUNC_VOICE       = 1'b1
    } ncvm_func_t;

    // Output channel roles
    typedef enum logic [1:0] {
        ROLE_PITCH = 2'd0,
        ROLE_GATE  = 2'd1,
        ROLE_VEL   = 2'd2,
        ROLE_TRIG  = 2'd3
    } ncvm_role_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_PITCH,
        ST_GATE,
        ST_VEL,
        ST_TRIG
    } ncvm_state_t;

    typedef struct packed {
        logic              pitch_enable;
        logic [2:0]        voice_count;
        logic signed [6:0] transpose;
        logic [7:0]        notes_per_octave;
        logic [15:0]       glide_time;
    } ncvm_cfg_t;

    typedef struct packed {
        ncvm_func_t         func;
        logic [1:0]         voice;
        logic signed [7:0]  note;
        logic [6:0]         velocity;
        logic signed [13:0] pitch_bend;
        logic [TAB_AW-1:0]  table_index;
        logic [15:0]        table_value;
    } ncvm_item_t;

    typedef struct packed {
        logic               group;
        logic [1:0]         slot_base;
        ncvm_role_t         role;
        logic               set_time;
        logic [15:0]        ramp_time;
        logic signed [17:0] target;
        logic               start_trigger;
        logic               last;
    } ncvm_result_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } ncvm_div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
        logic [7:0]  remainder;
    } ncvm_div_rsp_t;

endpackage

### design/ncvm_div.sv
// ----------------------------------------------------------------------------
// ncvm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ncvm_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ncvm_pkg::ncvm_div_req_t req,
    output ncvm_pkg::ncvm_div_rsp_t rsp
);
    import ncvm_pkg::*;

    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      quo_reg;
    logic [7:0]       rem_reg;
    logic [7:0]       dsr_reg;

    logic [8:0]       shifted;
    logic [9:0]       diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[15]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = ~diff[9];

    // Control: run for DIV_STEPS steps, flag done for one cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one quotient bit in per step
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[14:0], fits};
            rem_reg <= fits ? diff[7:0] : shifted[7:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### design/ncvm_tuning_ram.sv
// ----------------------------------------------------------------------------
// ncvm_tuning_ram
// Tuning table of DAC words, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ncvm_tuning_ram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ncvm_pkg::TAB_AW-1:0] waddr,
    input  logic [15:0]                 wdata,
    input  logic [ncvm_pkg::TAB_AW-1:0] raddr,
    output logic [15:0]                 rdata
);
    import ncvm_pkg::*;

    logic [15:0] mem [TABLE_DEPTH];
    logic [15:0] rdata_reg;

    // Write one word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ncvm_seq.sv
// ----------------------------------------------------------------------------
// ncvm_seq
// Sequencer: pitch lookup, via the shared divider for sums outside 0..127,
// then command emission through a single output register.
// ----------------------------------------------------------------------------
module ncvm_seq #(
    parameter int MAX_VOICES = ncvm_pkg::MAX_VOICES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ncvm_pkg::ncvm_cfg_t         cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ncvm_pkg::ncvm_item_t        s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ncvm_pkg::ncvm_result_t      m_result,
    output ncvm_pkg::ncvm_div_req_t     div_req,
    input  ncvm_pkg::ncvm_div_rsp_t     div_rsp,
    output logic                        ram_we,
    output logic [ncvm_pkg::TAB_AW-1:0] ram_waddr,
    output logic [15:0]                 ram_wdata,
    output logic [ncvm_pkg::TAB_AW-1:0] ram_raddr,
    input  logic [15:0]                 ram_rdata
);
    import ncvm_pkg::*;

    ncvm_state_t        state_reg, state_next;

    logic               on_reg;
    logic               trig_reg;
    logic [1:0]         voice_reg;
    logic [6:0]         vel_reg;
    logic signed [13:0] bend_reg;
    logic signed [8:0]  sum_reg;
    logic signed [8:0]  last_pitch_reg;
    logic [TAB_AW-1:0]  idx_reg;
    logic [15:0]        oct_reg;
    logic [15:0]        prod_reg;
    logic signed [17:0] target_reg;

    logic               out_valid_reg;
    ncvm_result_t       out_reg;

    logic               accept;
    logic               go;
    logic [2:0]         nv;
    logic               mono;
    logic               big;
    logic signed [8:0]  sum_in;
    logic [7:0]         card;
    logic [28:0]        prod_full;
    logic [15:0]        pitch;
    logic               out_free;
    logic               load_out;
    ncvm_result_t       out_next;

    // Voices in use, saturated to the supported count
    assign nv     = (cfg.voice_count > 3'(MAX_VOICES)) ? 3'(MAX_VOICES) : cfg.voice_count;
    assign mono   = (nv == 3'd1);
    assign accept = s_valid && s_ready;
    assign go     = (s_item.func == FUNC_VOICE) && cfg.pitch_enable
                    && ({1'b0, s_item.voice} < nv);
    assign sum_in = {s_item.note[7], s_item.note} + {{2{cfg.transpose[6]}}, cfg.transpose};

    // Sum outside 0..127 takes the octave split
    assign big  = sum_reg[8] | sum_reg[7];
    assign card = (cfg.notes_per_octave == 8'd0) ? 8'd1 : cfg.notes_per_octave;

    assign prod_full = 29'(oct_reg) * 29'(OCTAVE_STEP);
    assign pitch     = ram_rdata + prod_reg;
    assign out_free  = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && go) begin
                    state_next = s_item.note[7] ? ST_GATE : ST_START;
                end
            end
            ST_START: begin
                state_next = big ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = ST_PITCH;
            end
            ST_PITCH: begin
                if (out_free) begin
                    state_next = ST_GATE;
                end
            end
            ST_GATE: begin
                if (out_free) begin
                    state_next = ST_VEL;
                end
            end
            ST_VEL: begin
                if (out_free) begin
                    state_next = (on_reg && trig_reg) ? ST_TRIG : ST_IDLE;
                end
            end
            ST_TRIG: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, unit requests and the command to emit
    always_comb begin
        s_ready          = 1'b0;
        ram_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {{7{sum_reg[8]}}, sum_reg};
        div_req.divisor  = card;
        load_out         = 1'b0;
        out_next.group         = voice_reg[1];
        out_next.slot_base     = voice_reg[0] ? 2'd3 : 2'd0;
        out_next.role          = ROLE_PITCH;
        out_next.set_time      = 1'b1;
        out_next.ramp_time     = cfg.glide_time;
        out_next.target        = target_reg;
        out_next.start_trigger = 1'b0;
        out_next.last          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ram_we  = s_valid && (s_item.func == FUNC_TABLE_WRITE);
            end
            ST_START: begin
                div_req.start = big;
            end
            ST_PITCH: begin
                load_out = out_free;
            end
            ST_GATE: begin
                load_out           = out_free;
                out_next.role      = ROLE_GATE;
                out_next.set_time  = on_reg;
                out_next.ramp_time = '0;
                out_next.target    = on_reg ? GATE_ON : '0;
            end
            ST_VEL: begin
                load_out           = out_free;
                out_next.role      = ROLE_VEL;
                out_next.set_time  = on_reg;
                out_next.ramp_time = on_reg ? VEL_RAMP : '0;
                out_next.target    = on_reg ? {6'd0, vel_reg, 5'd0} : '0;
                out_next.last      = !(on_reg && trig_reg);
            end
            ST_TRIG: begin
                load_out               = out_free;
                out_next.group         = 1'b0;
                out_next.slot_base     = 2'd0;
                out_next.role          = ROLE_TRIG;
                out_next.set_time      = 1'b0;
                out_next.ramp_time     = '0;
                out_next.target        = TRIG_LEVEL;
                out_next.start_trigger = 1'b1;
                out_next.last          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_pitch_reg <= -9'sd1;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            // Note-off clears the last pitch, note-on records the sum
            if (accept && go && s_item.note[7]) begin
                last_pitch_reg <= -9'sd1;
            end else if (state_reg == ST_ADD) begin
                last_pitch_reg <= sum_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            on_reg    <= !s_item.note[7];
            voice_reg <= s_item.voice;
            vel_reg   <= s_item.velocity;
            bend_reg  <= s_item.pitch_bend;
            sum_reg   <= sum_in;
        end
        // Table index and octave: direct for small sums, else from the divider
        if (state_reg == ST_START && !big) begin
            idx_reg <= sum_reg[TAB_AW-1:0];
            oct_reg <= '0;
        end else if (state_reg == ST_DIV && div_rsp.done) begin
            idx_reg <= div_rsp.remainder[TAB_AW-1:0];
            oct_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_full[15:0];
        end
        if (state_reg == ST_ADD) begin
            target_reg <= $signed({2'b00, pitch}) + 18'(bend_reg);
            trig_reg   <= mono && (last_pitch_reg != sum_reg);
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign ram_waddr = s_item.table_index;
    assign ram_wdata = s_item.table_value;
    assign ram_raddr = idx_reg;
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

endmodule

### design/note_to_cv_voice_mapper_top.sv
// ----------------------------------------------------------------------------
// note_to_cv_voice_mapper_top
// Maps voice note state to pitch, gate, velocity and trigger ramp commands.
//
//   Channel   Dir  Handshake          Content
//   s_*       in   s_tvalid/s_tready  table write or voice update
//   m_*       out  m_tvalid/m_tready  one ramp command per transfer
//   cfg_*     in   cfg_valid/cfg_ready register index and write data
//
// Table write, ignored item: idle only. Note-off: gate, velocity.
// Note-on in 0..127 after transpose: start, mul, add, pitch, gate,
// velocity, trigger if due; others via the 16-step shared divider.
// Reset is synchronous, active low; it restores register defaults and
// clears control state, the tuning table is left as it is.
// An output stall holds the output register and the emitting states.
// ----------------------------------------------------------------------------
module note_to_cv_voice_mapper_top #(
    parameter int MAX_VOICES = ncvm_pkg::MAX_VOICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // voice, note, velocity, pitch_bend,
                                   // table_index, table_value, zero pad
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // group, slot_base, set_time, ramp_time,
                                   // target, start_trigger, zero pad
    output logic [1:0]  m_tuser,   // role
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import ncvm_pkg::*;

    ncvm_cfg_t     cfg_reg;
    ncvm_item_t    item;
    ncvm_result_t  result;
    ncvm_div_req_t div_req;
    ncvm_div_rsp_t div_rsp;

    logic              ram_we;
    logic [TAB_AW-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [TAB_AW-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_enable     <= 1'b1;
            cfg_reg.voice_count      <= 3'd1;
            cfg_reg.transpose        <= '0;
            cfg_reg.notes_per_octave <= 8'd12;
            cfg_reg.glide_time       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_PITCH_ENABLE: cfg_reg.pitch_enable     <= cfg_data[0];
                REG_VOICE_COUNT:  cfg_reg.voice_count      <= cfg_data[2:0];
                REG_TRANSPOSE:    cfg_reg.transpose        <= cfg_data[6:0];
                REG_NOTES_OCT:    cfg_reg.notes_per_octave <= cfg_data[7:0];
                REG_GLIDE_TIME:   cfg_reg.glide_time       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input transfer
    assign item.func        = ncvm_func_t'(s_tuser[0]);
    assign item.voice       = s_tdata[1:0];
    assign item.note        = s_tdata[9:2];
    assign item.velocity    = s_tdata[16:10];
    assign item.pitch_bend  = s_tdata[30:17];
    assign item.table_index = s_tdata[37:31];
    assign item.table_value = s_tdata[53:38];

    ncvm_seq #(
        .MAX_VOICES (MAX_VOICES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_item    (item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ncvm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    ncvm_tuning_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pack the output transfer
    assign m_tdata = {1'b0, result.start_trigger, result.target, result.ramp_time,
                      result.set_time, result.slot_base, result.group};
    assign m_tuser = result.role;
    assign m_tlast = result.last;

endmodule

### design/ncvm_checker.sv
// ----------------------------------------------------------------------------
// ncvm_checker
// Port-level checks on the result channel of the voice mapper.
// ----------------------------------------------------------------------------
`include "note_to_cv_voice_mapper_top_assert.svh"

module ncvm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import ncvm_pkg::*;

    // A stalled command holds
    `NCVM_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled command changed")

    // A trigger carries the start flag and ends its item
    `NCVM_ASSERT_IMP(a_trig_last, aclk, aresetn, m_tvalid && (m_tuser == ROLE_TRIG), m_tlast && m_tdata[38] && (m_tdata[37:20] == 18'd65535), "trigger command malformed")

    // A pitch command never ends its item
    `NCVM_ASSERT_IMP(a_pitch_not_last, aclk, aresetn, m_tvalid && (m_tuser == ROLE_PITCH), !m_tlast && m_tdata[3] && !m_tdata[38], "pitch command marked last")

    // Gate on goes to level 4095 with zero ramp time
    `NCVM_ASSERT_IMP(a_gate_on, aclk, aresetn, m_tvalid && (m_tuser == ROLE_GATE) && m_tdata[3], (m_tdata[37:20] == 18'd4095) && (m_tdata[19:4] == 16'd0), "gate on command malformed")

endmodule

bind note_to_cv_voice_mapper_top ncvm_checker u_ncvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
